@@ hdl/assert_macros.svh @@
// assertion macros used by the audio path core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hdl/fir7avp_pkg.sv @@
// package: constants, types and coefficient function of the fir audio volume path
package fir7avp_pkg;

    localparam int TAP_COUNT      = 7;
    localparam int COEF_FRAC_BITS = 15;
    localparam int BASE_TAPS      = 7;

    localparam int SAMPLE_W = 12;
    localparam int COEF_W   = COEF_FRAC_BITS + 1;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int SUM_W    = PROD_W + $clog2(TAP_COUNT) + 1;
    localparam int BASE_W   = SAMPLE_W + 1;
    localparam int VOL_W    = 10;
    localparam int OUT_W    = BASE_W + 2;

    // adder tree: groups of four products, then one sum over the groups
    localparam int GROUP       = 4;
    localparam int GROUP_COUNT = (TAP_COUNT + GROUP - 1) / GROUP;

    // input kinds carried in tuser
    localparam logic [1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [1:0] MODE_VOL_UP   = 2'd1;
    localparam logic [1:0] MODE_VOL_DOWN = 2'd2;

    // filter_mode register codes, anything above is bypass
    localparam logic [1:0] FMODE_SET_A  = 2'd0;
    localparam logic [1:0] FMODE_SET_B  = 2'd1;
    localparam logic [1:0] FMODE_BYPASS = 2'd2;

    localparam logic signed [VOL_W:0]   VOL_STEP = 11'sd10;
    localparam logic signed [VOL_W:0]   VOL_MAX  = 11'sd300;
    localparam logic signed [VOL_W:0]   VOL_MIN  = -11'sd300;
    localparam logic signed [VOL_W-1:0] VOL_MUTE = -10'sd300;

    localparam logic [SAMPLE_W-1:0] CODE_MAX = 12'd4095;
    localparam logic [BASE_W-1:0]   BASE_MAX = {BASE_W{1'b1}};

    typedef struct packed {
        logic                      bypass;
        logic [SAMPLE_W-1:0]       sample;
        logic signed [VOL_W-1:0]   vol;
    } t_meta;

    typedef struct packed {
        logic  valid;
        t_meta meta;
    } t_flow;

    // coefficient of one tap in fixed point, halves rounded away from zero
    function automatic logic signed [COEF_W-1:0] coef_fixed(input logic set_b, input int idx);
        longint dec;
        longint mag;
        longint q;
        dec = 0;
        if (!set_b) begin
            case (idx)
                0: dec = -1050;
                1: dec = -1448;
                2: dec = -1721;
                3: dec = 8182;
                4: dec = -1721;
                5: dec = -1448;
                6: dec = -1050;
                default: dec = 0;
            endcase
        end else begin
            case (idx)
                0: dec = 302;
                1: dec = 360;
                2: dec = 397;
                3: dec = 909;
                4: dec = 897;
                5: dec = 860;
                6: dec = 802;
                default: dec = 0;
            endcase
        end
        mag = (dec < 0) ? -dec : dec;
        q = ((mag * (longint'(1) << COEF_FRAC_BITS)) * 2 + 10000) / 20000;
        if (dec < 0) begin
            q = -q;
        end
        return COEF_W'(q);
    endfunction

endpackage

@@ hdl/fir7_audio_volume_path_core.sv @@
// Audio path core: a 7-tap FIR (two coefficient sets or bypass) with a stepped volume offset,
// mute at the lowest step and saturation to the 12-bit DAC range. One word is taken every
// clock unless the output stalls; a sample word passes the tap cells (registered products),
// two adder-tree stages, a magnitude stage and an offset and saturation stage; volume words
// are absorbed on arrival with no output. The delay line shifts only on filtered samples.
// filter_mode must be written through i_cfg_we only while the path is empty; not enforced.
`include "assert_macros.svh"

module fir7_audio_volume_path_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,     // filter_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [11:0] sample, [15:12] zero
    input  logic [1:0]  s_axis_tuser,    // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [11:0] dac_code, [15:12] zero
);

    localparam int TAPS = fir7avp_pkg::TAP_COUNT;

    logic [1:0]                                    r_fmode;
    logic signed [fir7avp_pkg::VOL_W-1:0]          r_vol;
    logic signed [fir7avp_pkg::VOL_W-1:0]          n_vol;
    logic signed [fir7avp_pkg::VOL_W:0]            w_vol_ext;
    logic signed [fir7avp_pkg::VOL_W:0]            w_vol_up;
    logic signed [fir7avp_pkg::VOL_W:0]            w_vol_dn;

    logic                                          w_accept;
    logic                                          w_is_sample;
    logic                                          w_bypass;
    logic                                          w_shift;
    logic [fir7avp_pkg::SAMPLE_W-1:0]              w_sample;

    logic [fir7avp_pkg::SAMPLE_W-1:0]              w_tap  [TAPS];
    logic signed [fir7avp_pkg::PROD_W-1:0]         w_prod [TAPS];

    logic                                          r_v1;
    fir7avp_pkg::t_meta                            r_m1;
    fir7avp_pkg::t_flow                            w_flow1;
    fir7avp_pkg::t_flow                            w_flow3;
    logic signed [fir7avp_pkg::SUM_W-1:0]          w_sum3;
    logic                                          w_rdy1;
    logic                                          w_rdy2;

    logic                                          r_v4;
    fir7avp_pkg::t_meta                            r_m4;
    logic [fir7avp_pkg::BASE_W-1:0]                r_base4;
    logic [fir7avp_pkg::BASE_W-1:0]                n_base4;
    logic [fir7avp_pkg::SUM_W-1:0]                 w_mag;
    logic [fir7avp_pkg::SUM_W-1:0]                 w_shifted;
    logic                                          w_rdy4;

    logic                                          r_v5;
    logic [fir7avp_pkg::SAMPLE_W-1:0]              r_out;
    logic [fir7avp_pkg::SAMPLE_W-1:0]              n_out;
    logic signed [fir7avp_pkg::OUT_W-1:0]          w_y;
    logic                                          w_rdy5;

    // ready chain, each stage loads when empty or when its successor moves
    assign w_rdy5        = !r_v5 || m_axis_tready;
    assign w_rdy4        = !r_v4 || w_rdy5;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    assign w_accept    = s_axis_tvalid && w_rdy1;
    assign w_is_sample = (s_axis_tuser == fir7avp_pkg::MODE_SAMPLE);
    assign w_bypass    = (r_fmode != fir7avp_pkg::FMODE_SET_A)
                      && (r_fmode != fir7avp_pkg::FMODE_SET_B);
    assign w_shift     = w_accept && w_is_sample && !w_bypass;
    assign w_sample    = s_axis_tdata[fir7avp_pkg::SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmode <= fir7avp_pkg::FMODE_SET_A;
        end else if (i_cfg_we) begin
            r_fmode <= i_cfg_wdata;
        end
    end

    // volume offset, clamped at both ends
    assign w_vol_ext = {r_vol[fir7avp_pkg::VOL_W-1], r_vol};
    assign w_vol_up  = w_vol_ext + fir7avp_pkg::VOL_STEP;
    assign w_vol_dn  = w_vol_ext - fir7avp_pkg::VOL_STEP;

    always_comb begin
        n_vol = r_vol;
        if (w_accept) begin
            case (s_axis_tuser)
                fir7avp_pkg::MODE_VOL_UP: begin
                    if (w_vol_up > fir7avp_pkg::VOL_MAX) begin
                        n_vol = fir7avp_pkg::VOL_MAX[fir7avp_pkg::VOL_W-1:0];
                    end else begin
                        n_vol = w_vol_up[fir7avp_pkg::VOL_W-1:0];
                    end
                end
                fir7avp_pkg::MODE_VOL_DOWN: begin
                    if (w_vol_dn < fir7avp_pkg::VOL_MIN) begin
                        n_vol = fir7avp_pkg::VOL_MIN[fir7avp_pkg::VOL_W-1:0];
                    end else begin
                        n_vol = w_vol_dn[fir7avp_pkg::VOL_W-1:0];
                    end
                end
                default: n_vol = r_vol;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= '0;
        end else begin
            r_vol <= n_vol;
        end
    end

    // row of tap cells, cell 0 holds the newest sample
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic [fir7avp_pkg::SAMPLE_W-1:0] w_prev;
        if (k == 0) begin : g_head
            assign w_prev = w_sample;
        end else begin : g_link
            assign w_prev = w_tap[k-1];
        end
        fir7avp_tap_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_shift),
            .i_load     (w_rdy1),
            .i_set_b    (r_fmode == fir7avp_pkg::FMODE_SET_B),
            .i_prev_tap (w_prev),
            .i_coef_a   (fir7avp_pkg::coef_fixed(1'b0, k)),
            .i_coef_b   (fir7avp_pkg::coef_fixed(1'b1, k)),
            .o_tap      (w_tap[k]),
            .o_prod     (w_prod[k])
        );
    end

    // stage 1 runs alongside the product registers in the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= w_accept && w_is_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_m1.bypass <= w_bypass;
            r_m1.sample <= w_sample;
            r_m1.vol    <= r_vol;
        end
    end

    assign w_flow1.valid = r_v1;
    assign w_flow1.meta  = r_m1;

    fir7avp_acc_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (w_prod),
        .i_flow  (w_flow1),
        .o_ready (w_rdy2),
        .o_flow  (w_flow3),
        .o_sum   (w_sum3),
        .i_ready (w_rdy4)
    );

    // magnitude, drop the fraction, clip to the base width; bypass passes the raw sample
    assign w_mag     = w_sum3[fir7avp_pkg::SUM_W-1] ? fir7avp_pkg::SUM_W'(-w_sum3)
                                                   : fir7avp_pkg::SUM_W'(w_sum3);
    assign w_shifted = w_mag >> fir7avp_pkg::COEF_FRAC_BITS;

    always_comb begin
        if (w_flow3.meta.bypass) begin
            n_base4 = {1'b0, w_flow3.meta.sample};
        end else if (|w_shifted[fir7avp_pkg::SUM_W-1:fir7avp_pkg::BASE_W]) begin
            n_base4 = fir7avp_pkg::BASE_MAX;
        end else begin
            n_base4 = w_shifted[fir7avp_pkg::BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= w_flow3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_m4    <= w_flow3.meta;
            r_base4 <= n_base4;
        end
    end

    // volume offset, mute and saturation into the output register
    assign w_y = $signed({2'b00, r_base4})
               + $signed({{(fir7avp_pkg::OUT_W - fir7avp_pkg::VOL_W){r_m4.vol[fir7avp_pkg::VOL_W-1]}},
                          r_m4.vol});

    always_comb begin
        if (r_m4.vol == fir7avp_pkg::VOL_MUTE || w_y < 0) begin
            n_out = '0;
        end else if (w_y > $signed({3'b000, fir7avp_pkg::CODE_MAX})) begin
            n_out = fir7avp_pkg::CODE_MAX;
        end else begin
            n_out = w_y[fir7avp_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {4'b0000, r_out};

    `ASSERT_RST(a_vol_range, i_clk, i_rst_n, (r_vol >= fir7avp_pkg::VOL_MUTE) && (r_vol <= -fir7avp_pkg::VOL_MUTE))
    `ASSERT_RST(a_bypass_holds_taps, i_clk, i_rst_n, (w_accept && w_is_sample && w_bypass) |=> $stable(w_tap[0]))
    `ASSERT_RST(a_no_word_from_press, i_clk, i_rst_n, (w_accept && !w_is_sample) |=> !r_v1)
    `ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

@@ hdl/fir7avp_tap_cell.sv @@
// one delay line cell: holds a tap, hands it to the next cell, registers its product
module fir7avp_tap_cell (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_shift,
    input  logic                                              i_load,
    input  logic                                              i_set_b,
    input  logic [fir7avp_pkg::SAMPLE_W-1:0]                  i_prev_tap,
    input  logic signed [fir7avp_pkg::COEF_W-1:0]             i_coef_a,
    input  logic signed [fir7avp_pkg::COEF_W-1:0]             i_coef_b,
    output logic [fir7avp_pkg::SAMPLE_W-1:0]                  o_tap,
    output logic signed [fir7avp_pkg::PROD_W-1:0]             o_prod
);

    logic [fir7avp_pkg::SAMPLE_W-1:0]      r_tap;
    logic [fir7avp_pkg::SAMPLE_W-1:0]      n_tap;
    logic signed [fir7avp_pkg::PROD_W-1:0] r_prod;
    logic signed [fir7avp_pkg::PROD_W-1:0] n_prod;
    logic signed [fir7avp_pkg::COEF_W-1:0] w_coef;

    assign n_tap  = i_shift ? i_prev_tap : r_tap;
    assign w_coef = i_set_b ? i_coef_b : i_coef_a;
    // product of the tap as it stands after this edge
    assign n_prod = fir7avp_pkg::PROD_W'(w_coef) * fir7avp_pkg::PROD_W'($signed({1'b0, n_tap}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_tap  = r_tap;
    assign o_prod = r_prod;

endmodule

@@ hdl/fir7avp_acc_tree.sv @@
// two-stage registered adder tree over the tap products
module fir7avp_acc_tree (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic signed [fir7avp_pkg::PROD_W-1:0]      i_prod [fir7avp_pkg::TAP_COUNT],
    input  fir7avp_pkg::t_flow                         i_flow,
    output logic                                       o_ready,
    output fir7avp_pkg::t_flow                         o_flow,
    output logic signed [fir7avp_pkg::SUM_W-1:0]       o_sum,
    input  logic                                       i_ready
);

    logic                                  r_v2;
    fir7avp_pkg::t_meta                    r_m2;
    logic signed [fir7avp_pkg::SUM_W-1:0]  r_grp [fir7avp_pkg::GROUP_COUNT];
    logic signed [fir7avp_pkg::SUM_W-1:0]  n_grp [fir7avp_pkg::GROUP_COUNT];
    logic                                  r_v3;
    fir7avp_pkg::t_meta                    r_m3;
    logic signed [fir7avp_pkg::SUM_W-1:0]  r_total;
    logic signed [fir7avp_pkg::SUM_W-1:0]  n_total;
    logic                                  w_rdy2;
    logic                                  w_rdy3;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    always_comb begin
        for (int g = 0; g < fir7avp_pkg::GROUP_COUNT; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < fir7avp_pkg::GROUP; j++) begin
                if (g * fir7avp_pkg::GROUP + j < fir7avp_pkg::TAP_COUNT) begin
                    n_grp[g] = n_grp[g]
                        + fir7avp_pkg::SUM_W'(i_prod[g * fir7avp_pkg::GROUP + j]);
                end
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int g = 0; g < fir7avp_pkg::GROUP_COUNT; g++) begin
            n_total = n_total + r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_flow.valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_m2  <= i_flow.meta;
            r_grp <= n_grp;
        end
        if (w_rdy3) begin
            r_m3    <= r_m2;
            r_total <= n_total;
        end
    end

    assign o_flow.valid = r_v3;
    assign o_flow.meta  = r_m3;
    assign o_sum        = r_total;

endmodule

@@ test/fir7_audio_volume_path_core_test.sv @@
// self-checking testbench for the fir audio volume path core
module fir7_audio_volume_path_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_IGNORED = 2'd3;   // kind the core drops
    localparam logic [1:0] FMODE_SPARE  = 2'd3;   // decodes as bypass
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 300;

    class dac_code_scoreboard;
        localparam int VOL_STEP  = 10;
        localparam int VOL_LIMIT = 300;
        localparam int CODE_TOP  = 4095;

        int          coef_a[fir7avp_pkg::TAP_COUNT];
        int          coef_b[fir7avp_pkg::TAP_COUNT];
        logic [11:0] taps[fir7avp_pkg::TAP_COUNT];
        logic [1:0]  filter_mode;
        int          volume;
        logic [11:0] dac_codes_due[$];
        int          mismatches;

        function new();
            coef_a = '{-3441, -4745, -5639, 26811, -5639, -4745, -3441};
            coef_b = '{990, 1180, 1301, 2979, 2939, 2818, 2628};
            foreach (taps[i]) taps[i] = '0;
            filter_mode = fir7avp_pkg::FMODE_SET_A;
            volume = 0;
            mismatches = 0;
        endfunction

        function void set_filter_mode(logic [1:0] fm);
            filter_mode = fm;
        endfunction

        // code the core must emit for a sample, updating the delay line when filtering
        function logic [11:0] next_dac_code(logic [11:0] smp);
            longint acc;
            longint mag;
            longint y;
            if (filter_mode == fir7avp_pkg::FMODE_SET_A
                    || filter_mode == fir7avp_pkg::FMODE_SET_B) begin
                for (int i = fir7avp_pkg::TAP_COUNT - 1; i > 0; i--) taps[i] = taps[i-1];
                taps[0] = smp;
                acc = 0;
                for (int i = 0; i < fir7avp_pkg::TAP_COUNT; i++) begin
                    acc += longint'(filter_mode == fir7avp_pkg::FMODE_SET_A ?
                                    coef_a[i] : coef_b[i])
                           * longint'(taps[i]);
                end
                mag = (acc < 0) ? -acc : acc;
                mag = mag >> fir7avp_pkg::COEF_FRAC_BITS;
            end else begin
                mag = longint'(smp);
            end
            y = mag + volume;
            if (volume == -VOL_LIMIT) y = 0;
            if (y < 0) y = 0;
            if (y > CODE_TOP) y = CODE_TOP;
            return 12'(y);
        endfunction

        function void note_word(logic [1:0] mode, logic [11:0] smp);
            case (mode)
                fir7avp_pkg::MODE_SAMPLE:   dac_codes_due.push_back(next_dac_code(smp));
                fir7avp_pkg::MODE_VOL_UP:   volume = (volume + VOL_STEP > VOL_LIMIT) ?
                                                     VOL_LIMIT : volume + VOL_STEP;
                fir7avp_pkg::MODE_VOL_DOWN: volume = (volume - VOL_STEP < -VOL_LIMIT) ?
                                                     -VOL_LIMIT : volume - VOL_STEP;
                default: ;
            endcase
        endfunction

        function void check_code(logic [11:0] code);
            logic [11:0] want;
            if (dac_codes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: dac_code %0d", code);
            end else begin
                want = dac_codes_due.pop_front();
                if (code !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("dac_code mismatch: expected %0d, got %0d", want, code);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [11:0] sample, [15:12] zero
    logic [1:0]  s_axis_tuser = '0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [11:0] dac_code, [15:12] zero

    dac_code_scoreboard book;
    bit sender_steady = 1'b0;
    bit hold_request = 1'b0;

    fir7_audio_volume_path_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [11:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic [1:0] mode, input logic [11:0] smp);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 99) < 30) gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'd0, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book.note_word(mode, smp);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.dac_codes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_filter_mode(input logic [1:0] fm);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fm;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_filter_mode(fm);
    endtask

    task automatic volume_run(input logic [1:0] mode, input int n);
        repeat (n) send_word(mode, rand_sample());
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int stall_left;
        int calm_left;
        bit calm;
        stall_left = 0;
        calm_left = 0;
        calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 80);
            end else begin
                calm_left--;
            end
            if (hold_request) begin
                stall_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) book.check_code(m_axis_tdata[11:0]);
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int sent;
        int n;
        int r;
        logic [1:0] fm;
        book = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: both coefficient sets, bypass, spare code, extremes
        write_filter_mode(fir7avp_pkg::FMODE_SET_A);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h000);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h555);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hAAA);
        send_word(MODE_IGNORED, 12'hFFF);
        send_word(fir7avp_pkg::MODE_VOL_UP, 12'h000);
        send_word(fir7avp_pkg::MODE_VOL_DOWN, 12'hFFF);
        send_word(fir7avp_pkg::MODE_VOL_DOWN, 12'h000);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        write_filter_mode(fir7avp_pkg::FMODE_SET_B);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h000);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h800);
        write_filter_mode(fir7avp_pkg::FMODE_BYPASS);
        send_word(fir7avp_pkg::MODE_VOL_UP, 12'h000);
        send_word(fir7avp_pkg::MODE_VOL_UP, 12'h000);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);    // saturates high
        send_word(fir7avp_pkg::MODE_VOL_DOWN, 12'h000);
        send_word(fir7avp_pkg::MODE_VOL_DOWN, 12'h000);
        send_word(fir7avp_pkg::MODE_VOL_DOWN, 12'h000);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h000);    // clamps at zero
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h7FF);
        write_filter_mode(FMODE_SPARE);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'hFFF);
        send_word(fir7avp_pkg::MODE_SAMPLE, 12'h001);
        send_word(MODE_IGNORED, 12'h000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: fm = fir7avp_pkg::FMODE_SET_B;
                1: fm = fir7avp_pkg::FMODE_SET_A;
                2: fm = fir7avp_pkg::FMODE_BYPASS;
                3: fm = FMODE_SPARE;
                default: fm = 2'($urandom_range(0, 3));
            endcase
            write_filter_mode(fm);
            sender_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            sent = 0;
            // walk the offset to the floor (mute) and then past the ceiling
            if (p == 0) begin
                volume_run(fir7avp_pkg::MODE_VOL_DOWN, 32);
                sent += 32;
            end else if (p == 1) begin
                volume_run(fir7avp_pkg::MODE_VOL_UP, 65);
                sent += 65;
            end else if (p == 2) begin
                hold_request = 1'b1;
            end
            while (sent < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    n = $urandom_range(31, 35);
                    volume_run($urandom_range(0, 1) ? fir7avp_pkg::MODE_VOL_UP
                                                    : fir7avp_pkg::MODE_VOL_DOWN, n);
                    sent += n;
                end else if (r < 15) begin
                    n = $urandom_range(1, 4);
                    volume_run($urandom_range(0, 1) ? fir7avp_pkg::MODE_VOL_UP
                                                    : fir7avp_pkg::MODE_VOL_DOWN, n);
                    sent += n;
                end else if (r < 19) begin
                    send_word(MODE_IGNORED, rand_sample());
                end else begin
                    send_word(fir7avp_pkg::MODE_SAMPLE, rand_sample());
                    sent++;
                end
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (book.mismatches == 0 && book.dac_codes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fir7avp_pkg.sv
hdl/fir7avp_tap_cell.sv
hdl/fir7avp_acc_tree.sv
hdl/fir7_audio_volume_path_core.sv
test/fir7_audio_volume_path_core_test.sv
